// ===== design/tsrm_pkg.sv =====
`timescale 1ns / 1ps

package tsrm_pkg;

	// Field widths of the item and result
	localparam int FIELD_IDX_BITS   = 10;
	localparam int FIELD_VALUE_BITS = 32;

	// Operation codes
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// Store codes for writes
	localparam logic SEL_FIRST  = 1'b0;
	localparam logic SEL_SECOND = 1'b1;

	typedef struct packed {
		logic                               operation;
		logic                               store_select;
		logic        [FIELD_IDX_BITS-1:0]   write_index;
		logic signed [FIELD_VALUE_BITS-1:0] write_value;
		logic        [FIELD_IDX_BITS-1:0]   first_low;
		logic        [FIELD_IDX_BITS-1:0]   first_high;
		logic        [FIELD_IDX_BITS-1:0]   second_low;
		logic        [FIELD_IDX_BITS-1:0]   second_high;
	} item_t;

	typedef struct packed {
		logic signed [FIELD_VALUE_BITS-1:0] median_value;
		logic                               found;
	} result_t;

endpackage

// ===== design/tsrm_ram.sv =====
`timescale 1ns / 1ps

module tsrm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write one entry, read one entry registered
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== design/two_sorted_range_median_core.sv =====
`timescale 1ns / 1ps

// Channel   Ports                    Handshake
// item      start, busy, item        taken on an edge with start high and busy low
// result    done, result             done high for one cycle per query, no backpressure
//
// A write item goes straight into its store; busy stays low and no result follows.
// A query probes the own range by binary search, first range then second; each probe
// reads its own entry, then runs two rank counts over the other range, one strict and
// one non-strict. Each store has one registered read port, which sets the pace.
// Reset clears the sequencer only; store contents stay undefined until written.
// The result is shown on the cycle after the search ends, while a new item may enter.

module two_sorted_range_median_core
	import tsrm_pkg::*;
#(
	parameter int STORE_DEPTH = 1024,
	parameter int VALUE_BITS  = 32
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  item_t   item,
	output logic    done,
	output result_t result
);

	localparam int AW = $clog2(STORE_DEPTH);
	localparam int IW = ((AW > FIELD_IDX_BITS) ? AW : FIELD_IDX_BITS) + 3;

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_PROBE   = 3'd1;
	localparam logic [2:0] S_OWN_RD  = 3'd2;
	localparam logic [2:0] S_OWN_CAP = 3'd3;
	localparam logic [2:0] S_CNT     = 3'd4;
	localparam logic [2:0] S_CMP     = 3'd5;
	localparam logic [2:0] S_DECIDE  = 3'd6;

	localparam logic signed [IW-1:0] DEPTH_I = IW'(STORE_DEPTH);
	localparam logic signed [IW-1:0] ONE_I   = IW'(1);

	logic [2:0] state_q;

	// Query ranges and target rank
	logic signed [IW-1:0] lo1_q, len1_q, lo2_q, len2_q, k_q;
	// Outer search
	logic                 pass_q;
	logic signed [IW-1:0] left_q, right_q, mid_q;
	logic signed [VALUE_BITS-1:0] val_q;
	// Rank count
	logic signed [IW-1:0] cfirst_q, ccount_q, chalf_q, clo_q;
	logic                 eq_q;
	// Result
	logic    done_q;
	result_t result_q;

	// Range clipping at accept
	logic signed [IW-1:0] f_lo, f_hi, s_lo, s_hi;
	logic signed [IW-1:0] cl_lo1, cl_len1, cl_lo2, cl_len2;

	always_comb begin
		f_lo = IW'(item.first_low);
		s_lo = IW'(item.second_low);
		f_hi = (IW'(item.first_high) >= DEPTH_I) ? DEPTH_I - ONE_I : IW'(item.first_high);
		s_hi = (IW'(item.second_high) >= DEPTH_I) ? DEPTH_I - ONE_I : IW'(item.second_high);
		if (f_lo > f_hi) begin
			cl_lo1  = '0;
			cl_len1 = '0;
		end else begin
			cl_lo1  = f_lo;
			cl_len1 = f_hi - f_lo + ONE_I;
		end
		if (s_lo > s_hi) begin
			cl_lo2  = '0;
			cl_len2 = '0;
		end else begin
			cl_lo2  = s_lo;
			cl_len2 = s_hi - s_lo + ONE_I;
		end
	end

	// Write path
	logic                  accept;
	logic                  wr_ok;
	logic [VALUE_BITS-1:0] wr_val;
	logic [AW-1:0]         wr_addr;
	logic signed [IW-1:0]  wr_idx;

	assign accept  = start && !busy;
	assign wr_idx  = IW'(item.write_index);
	assign wr_ok   = accept && (item.operation == OP_WRITE) && (wr_idx < DEPTH_I);
	assign wr_addr = wr_idx[AW-1:0];

	generate
		if (VALUE_BITS <= FIELD_VALUE_BITS) begin : g_narrow
			assign wr_val = item.write_value[VALUE_BITS-1:0];
		end else begin : g_wide
			assign wr_val = {{(VALUE_BITS-FIELD_VALUE_BITS){1'b0}}, item.write_value};
		end
	endgenerate

	// Own and other range by pass
	logic signed [IW-1:0] own_lo, other_lo, other_len;
	assign own_lo    = pass_q ? lo2_q  : lo1_q;
	assign other_lo  = pass_q ? lo1_q  : lo2_q;
	assign other_len = pass_q ? len1_q : len2_q;

	// Read addresses
	logic signed [IW-1:0] chalf, cnt_idx;
	logic [AW-1:0]        own_addr, cnt_addr;
	logic [VALUE_BITS-1:0] rd1, rd2;
	logic signed [VALUE_BITS-1:0] own_rd, other_rd;

	assign chalf    = ccount_q >>> 1;
	assign cnt_idx  = other_lo + cfirst_q + chalf;
	assign own_addr = mid_q[AW-1:0];
	assign cnt_addr = cnt_idx[AW-1:0];
	assign own_rd   = pass_q ? rd2 : rd1;
	assign other_rd = pass_q ? rd1 : rd2;

	tsrm_ram #(
		.WIDTH(VALUE_BITS),
		.DEPTH(STORE_DEPTH)
	) u_first (
		.clk  (clk),
		.we   (wr_ok && (item.store_select == SEL_FIRST)),
		.waddr(wr_addr),
		.wdata(wr_val),
		.raddr(pass_q ? cnt_addr : own_addr),
		.rdata(rd1)
	);

	tsrm_ram #(
		.WIDTH(VALUE_BITS),
		.DEPTH(STORE_DEPTH)
	) u_second (
		.clk  (clk),
		.we   (wr_ok && (item.store_select == SEL_SECOND)),
		.waddr(wr_addr),
		.wdata(wr_val),
		.raddr(pass_q ? own_addr : cnt_addr),
		.rdata(rd2)
	);

	// Shared compare of entry against probe
	logic step;
	assign step = eq_q ? (other_rd <= val_q) : (other_rd < val_q);

	// Rank test of the probe
	logic signed [IW-1:0] p_rank, p_lo, p_hi;
	assign p_rank = mid_q - own_lo + ONE_I;
	assign p_lo   = p_rank + clo_q;
	assign p_hi   = p_rank + cfirst_q;

	// Result value zero-extended then cut to the field width
	logic [VALUE_BITS+FIELD_VALUE_BITS-1:0] val_ext;
	assign val_ext = {{FIELD_VALUE_BITS{1'b0}}, val_q};

	// Sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pass_q  <= 1'b0;
			eq_q    <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept && (item.operation == OP_QUERY)) begin
						pass_q  <= 1'b0;
						state_q <= S_PROBE;
					end
				end
				S_PROBE: begin
					if (left_q <= right_q) begin
						state_q <= S_OWN_RD;
					end else if (!pass_q) begin
						pass_q <= 1'b1;
					end else begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_OWN_RD: state_q <= S_OWN_CAP;
				S_OWN_CAP: begin
					eq_q    <= 1'b0;
					state_q <= S_CNT;
				end
				S_CNT: begin
					if (ccount_q > '0) begin
						state_q <= S_CMP;
					end else if (!eq_q) begin
						eq_q <= 1'b1;
					end else begin
						state_q <= S_DECIDE;
					end
				end
				S_CMP: state_q <= S_CNT;
				S_DECIDE: begin
					if (p_lo <= k_q && p_hi >= k_q) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_PROBE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Search datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept && (item.operation == OP_QUERY)) begin
					lo1_q   <= cl_lo1;
					len1_q  <= cl_len1;
					lo2_q   <= cl_lo2;
					len2_q  <= cl_len2;
					k_q     <= ((cl_len1 + cl_len2) >>> 1) + ONE_I;
					left_q  <= cl_lo1;
					right_q <= cl_lo1 + cl_len1 - ONE_I;
				end
			end
			S_PROBE: begin
				if (left_q <= right_q) begin
					mid_q <= (left_q + right_q) >>> 1;
				end else if (!pass_q) begin
					left_q  <= lo2_q;
					right_q <= lo2_q + len2_q - ONE_I;
				end else begin
					result_q.median_value <= '0;
					result_q.found        <= 1'b0;
				end
			end
			S_OWN_CAP: begin
				val_q    <= own_rd;
				cfirst_q <= '0;
				ccount_q <= other_len;
			end
			S_CNT: begin
				if (ccount_q > '0) begin
					chalf_q <= chalf;
				end else if (!eq_q) begin
					clo_q    <= cfirst_q;
					cfirst_q <= '0;
					ccount_q <= other_len;
				end
			end
			S_CMP: begin
				// Step past the probe or keep the lower half
				if (step) begin
					cfirst_q <= cfirst_q + chalf_q + ONE_I;
					ccount_q <= ccount_q - chalf_q - ONE_I;
				end else begin
					ccount_q <= chalf_q;
				end
			end
			S_DECIDE: begin
				if (p_lo <= k_q && p_hi >= k_q) begin
					result_q.median_value <= val_ext[FIELD_VALUE_BITS-1:0];
					result_q.found        <= 1'b1;
				end else if (p_lo < k_q) begin
					left_q <= mid_q + ONE_I;
				end else begin
					right_q <= mid_q - ONE_I;
				end
			end
			default: ;
		endcase
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = result_q;

endmodule
